@@ hw/rtl/lstk_pkg.sv @@
// Shared definitions for the byte LIFO stack with middle insert.
// Opcodes, status codes and default sizing; no dependencies.
package lstk_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int DATA_W          = 8;
    localparam int OP_W            = 3;
    localparam int COUNT_OUT_W     = 5;
    localparam int M_TDATA_W       = 16;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 3'd0,
        OP_POP   = 3'd1,
        OP_TOP   = 3'd2,
        OP_MID   = 3'd3,
        OP_CLEAR = 3'd4
    } opcode_t;

    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

endpackage

@@ hw/rtl/lifo_stack_with_middle_insert_core.sv @@
// Byte LIFO stack with push, pop, read top, middle insert and clear.
// Entries live in a single-port-write, registered-read memory; depends on lstk_pkg.
// Sequencing after request accept: push, clear, refusals and unused opcodes go
// straight to the finish state; pop and read top wait for the memory read; middle
// insert with n entries shifts n/2 entries, one memory move (read, then write) each.
// A new request is taken once the sequencer is back in idle; a finished result
// waits in the output register without blocking the next request.
// Reset clears the entry count; stored entries are left undefined, no clearing pass.
module lifo_stack_with_middle_insert_core
    import lstk_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [DATA_W-1:0]    s_tdata,   // [7:0] data_in
    input  logic [OP_W-1:0]      s_tuser,   // [2:0] opcode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // [7:0] data_out, [9:8] status,
                                            // [14:10] item_count_out, [15] empty_flag
);

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STACK_DEPTH);

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_RD_WAIT  = 5'b00010,
        ST_SHIFT_RD = 5'b00100,
        ST_SHIFT_WR = 5'b01000,
        ST_FINISH   = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [ADDR_W-1:0]   ptr_reg, ptr_next;
    logic [ADDR_W-1:0]   pos_reg, pos_next;
    logic [DATA_W-1:0]   byte_reg, byte_next;
    logic [DATA_W-1:0]   res_dout_reg, res_dout_next;
    status_t             res_status_reg, res_status_next;
    logic                m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;

    logic [DATA_W-1:0]   mem [STACK_DEPTH];
    logic [DATA_W-1:0]   rd_data_reg;
    logic                mem_we, mem_re;
    logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
    logic [DATA_W-1:0]   mem_wdata;

    logic [CNT_W-1:0]    count_dec;
    logic [CNT_W-1:0]    pos_full;
    logic [CNT_W+COUNT_OUT_W-1:0] count_ext;
    logic                cnt_empty, cnt_full;

    assign count_dec = count_reg - CNT_W'(1);
    assign pos_full  = count_reg - (count_reg >> 1);
    assign count_ext = {{COUNT_OUT_W{1'b0}}, count_reg};
    assign cnt_empty = (count_reg == '0);
    assign cnt_full  = (count_reg >= DEPTH_C);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        pos_next        = pos_reg;
        byte_next       = byte_reg;
        res_dout_next   = res_dout_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_waddr       = count_reg[ADDR_W-1:0];
        mem_raddr       = count_dec[ADDR_W-1:0];
        mem_wdata       = s_tdata;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    res_dout_next   = '0;
                    res_status_next = STAT_DONE;
                    state_next      = ST_FINISH;
                    case (s_tuser)
                        OP_PUSH: begin
                            if (cnt_full) begin
                                res_status_next = STAT_FULL;
                            end else begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_POP, OP_TOP: begin
                            if (cnt_empty) begin
                                res_status_next = STAT_EMPTY;
                            end else begin
                                mem_re     = 1'b1;
                                state_next = ST_RD_WAIT;
                                if (s_tuser == OP_POP) begin
                                    count_next = count_dec;
                                end
                            end
                        end
                        OP_MID: begin
                            if (cnt_empty) begin
                                res_status_next = STAT_EMPTY;
                            end else if (cnt_full) begin
                                res_status_next = STAT_FULL;
                            end else begin
                                ptr_next   = count_reg[ADDR_W-1:0];
                                pos_next   = pos_full[ADDR_W-1:0];
                                byte_next  = s_tdata;
                                state_next = ST_SHIFT_RD;
                            end
                        end
                        OP_CLEAR: begin
                            count_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RD_WAIT: begin
                res_dout_next = rd_data_reg;
                state_next    = ST_FINISH;
            end
            ST_SHIFT_RD: begin
                if (ptr_reg == pos_reg) begin
                    mem_we     = 1'b1;
                    mem_waddr  = pos_reg;
                    mem_wdata  = byte_reg;
                    count_next = count_reg + CNT_W'(1);
                    state_next = ST_FINISH;
                end else begin
                    mem_re     = 1'b1;
                    mem_raddr  = ptr_reg - ADDR_W'(1);
                    state_next = ST_SHIFT_WR;
                end
            end
            ST_SHIFT_WR: begin
                mem_we     = 1'b1;
                mem_waddr  = ptr_reg;
                mem_wdata  = rd_data_reg;
                ptr_next   = ptr_reg - ADDR_W'(1);
                state_next = ST_SHIFT_RD;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {cnt_empty, count_ext[COUNT_OUT_W-1:0],
                                    res_status_reg, res_dout_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        ptr_reg        <= ptr_next;
        pos_reg        <= pos_next;
        byte_reg       <= byte_next;
        res_dout_reg   <= res_dout_next;
        res_status_reg <= res_status_next;
        m_data_reg     <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_C)
        else $error("entry count exceeds stack depth");

    a_shift_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SHIFT_RD || state_reg == ST_SHIFT_WR)
        |-> (ptr_reg >= pos_reg) && (CNT_W'(ptr_reg) == count_reg || ptr_reg < count_reg))
        else $error("shift pointer out of range");

    a_push_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == OP_PUSH && !cnt_full)
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("push did not advance the entry count");

    a_shift_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SHIFT_WR) |-> $past(state_reg) == ST_SHIFT_RD)
        else $error("shift write without preceding read");

endmodule

@@ tb/testbench.sv @@
// Self-checking bench for lifo_stack_with_middle_insert_core: directed corner requests,
// biased random traffic and a long output stall, checked against a built-in stack model.
// Depends on lstk_pkg and the core RTL only.
module testbench;
    import lstk_pkg::*;

    localparam int STACK_DEPTH    = STACK_DEPTH_DEF;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int MAX_REPORTS    = 10;
    localparam int CHUNK_ITEMS    = 40;
    localparam int LONG_HOLD      = 300;

    localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic                   empty;
        logic [COUNT_OUT_W-1:0] count;
        status_t                status;
        logic [DATA_W-1:0]      data;
    } stack_result_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [DATA_W-1:0]    s_tdata  = '0;
    logic [OP_W-1:0]      s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    logic [DATA_W-1:0] model_bytes [STACK_DEPTH];
    int                model_count = 0;
    stack_result_t     expected_results [$];

    bit tx_idle = 1'b0;
    bit rx_idle = 1'b0;
    int rx_hold_cycles = 0;

    int mismatches    = 0;
    int requests_seen = 0;
    int results_seen  = 0;
    int mid_inserts   = 0;
    int empty_refused = 0;
    int full_refused  = 0;
    int quiet_cycles  = 0;

    lifo_stack_with_middle_insert_core #(
        .STACK_DEPTH (STACK_DEPTH)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic stack_result_t predict_stack_op(logic [OP_W-1:0] op,
                                                       logic [DATA_W-1:0] din);
        stack_result_t res;
        int            n;
        int            pos;
        res        = '0;
        res.status = STAT_DONE;
        n          = model_count;
        case (op)
            OP_PUSH: begin
                if (n >= STACK_DEPTH) begin
                    res.status = STAT_FULL;
                end else begin
                    model_bytes[n] = din;
                    n++;
                end
            end
            OP_POP: begin
                if (n == 0) begin
                    res.status = STAT_EMPTY;
                end else begin
                    n--;
                    res.data = model_bytes[n];
                end
            end
            OP_TOP: begin
                if (n == 0) res.status = STAT_EMPTY;
                else        res.data = model_bytes[n-1];
            end
            OP_MID: begin
                if (n == 0) begin
                    res.status = STAT_EMPTY;
                end else if (n >= STACK_DEPTH) begin
                    res.status = STAT_FULL;
                end else begin
                    pos = n - n / 2;
                    for (int i = n; i > pos; i--) model_bytes[i] = model_bytes[i-1];
                    model_bytes[pos] = din;
                    n++;
                end
            end
            OP_CLEAR: n = 0;
            default: ;
        endcase
        model_count = n;
        res.count   = n[COUNT_OUT_W-1:0];
        res.empty   = (n == 0);
        return res;
    endfunction

    function automatic void note_mismatch(string what, int exp_val, int act_val);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] %s: expected 0x%0h, got 0x%0h", $realtime, what, exp_val, act_val);
    endfunction

    // predict on request accept and queue it; check each result taken against the oldest prediction
    always @(posedge aclk) begin
        stack_result_t exp_r;
        stack_result_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                exp_r = predict_stack_op(s_tuser, s_tdata);
                requests_seen++;
                if (s_tuser == OP_MID && exp_r.status == STAT_DONE) mid_inserts++;
                if (exp_r.status == STAT_EMPTY) empty_refused++;
                if (exp_r.status == STAT_FULL) full_refused++;
                expected_results.push_back(exp_r);
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                results_seen++;
                if (expected_results.size() == 0) begin
                    note_mismatch("result with no request pending", 0, int'(m_tdata));
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got.data !== exp_r.data)
                        note_mismatch("data_out", int'(exp_r.data), int'(got.data));
                    if (got.status !== exp_r.status)
                        note_mismatch("status", int'(exp_r.status), int'(got.status));
                    if (got.count !== exp_r.count)
                        note_mismatch("item_count_out", int'(exp_r.count), int'(got.count));
                    if (got.empty !== exp_r.empty)
                        note_mismatch("empty_flag", int'(exp_r.empty), int'(got.empty));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                         WATCHDOG_LIMIT, expected_results.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // result side: random wait per result, plus an optional long hold
    initial begin
        int wait_cycles;
        @(posedge aclk iff aresetn);
        forever begin
            wait_cycles    = rx_hold_cycles + (rx_idle ? $urandom_range(0, 8) : 0);
            rx_hold_cycles = 0;
            if (wait_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic send_request(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] din);
        int gap;
        gap = tx_idle ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= din;
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic logic [OP_W-1:0] pick_op(int grow_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)                    return OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        if (r < 5)                           return OP_CLEAR;
        if (r < 5 + grow_pct * 3 / 5)        return OP_PUSH;
        if (r < 5 + grow_pct)                return OP_MID;
        if (r < 5 + grow_pct + (95 - grow_pct) / 3) return OP_TOP;
        return OP_POP;
    endfunction

    task automatic test_empty_and_unused_opcodes();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        send_request(OP_POP, 8'hFF);
        send_request(OP_TOP, 8'hFF);
        send_request(OP_MID, 8'hAA);
        send_request(OP_PUSH, 8'h00);
        send_request(OP_MID, 8'hFF);
        send_request(OP_UNUSED_LO, 8'hFF);
        send_request(OP_UNUSED_HI, 8'h55);
    endtask

    // grow from two entries to full with alternating push and middle insert, then probe full, pop and clear
    task automatic test_fill_to_full();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        for (int k = 0; k < STACK_DEPTH - 2; k++)
            send_request(k[0] ? OP_MID : OP_PUSH, DATA_W'(k * 37 + 1));
        send_request(OP_PUSH, 8'hFF);
        send_request(OP_MID, 8'h00);
        send_request(OP_TOP, 8'h00);
        send_request(OP_POP, 8'h00);
        send_request(OP_CLEAR, 8'hFF);
        send_request(OP_POP, 8'h00);
    endtask

    task automatic test_random_traffic(input int n_items);
        int grow_pct;
        for (int c = 0; c < n_items; c += CHUNK_ITEMS) begin
            case ($urandom_range(0, 2))
                0:       grow_pct = 70;
                1:       grow_pct = 25;
                default: grow_pct = 45;
            endcase
            tx_idle = ($urandom_range(0, 2) != 0);
            rx_idle = ($urandom_range(0, 2) != 0);
            for (int i = 0; i < CHUNK_ITEMS && c + i < n_items; i++)
                send_request(pick_op(grow_pct), DATA_W'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_output_backpressure();
        tx_idle        = 1'b0;
        rx_idle        = 1'b0;
        rx_hold_cycles = LONG_HOLD;
        repeat (20) send_request(pick_op(60), DATA_W'($urandom_range(0, 255)));
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_and_unused_opcodes();
        test_fill_to_full();
        test_random_traffic(900);
        test_output_backpressure();
        s_tvalid <= 1'b0;
        rx_idle = 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("run: %0d requests, %0d results, %0d middle inserts done",
                 requests_seen, results_seen, mid_inserts);
        $display("refusals: %0d on empty stack, %0d on full stack, %0d field mismatches",
                 empty_refused, full_refused, mismatches);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
